### rtl/snnew_pkg.sv
// snnew_pkg: shared constants, codes and control/status structs for the
// shared-nearest-neighbor edge weight engine. No dependencies.
`default_nettype none

package snnew_pkg;

    // fixed field widths
    localparam int ID_W     = 10;  // node / neighbor identifier
    localparam int SLOT_W   = 5;
    localparam int CFGK_W   = 6;
    localparam int MODE_W   = 2;
    localparam int WEIGHT_W = 22;
    localparam int SCNT_W   = 6;
    localparam int BRANK_W  = 7;
    localparam int FRAC_W   = 16;

    localparam int IN_TDATA_W  = 40;  // 35 payload bits, byte padded
    localparam int OUT_TDATA_W = 40;

    localparam int NODES_DEF = 1024;
    localparam int KMAX_DEF  = 32;

    localparam logic [CFGK_W-1:0] K_RESET = CFGK_W'(10);

    typedef enum logic [MODE_W-1:0] {
        MODE_COUNT = 2'd0,
        MODE_RANK  = 2'd1,
        MODE_JACC  = 2'd2,
        MODE_ALT   = 2'd3   // behaves as shared count
    } t_mode;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic CFG_IDX_K    = 1'b0;
    localparam logic CFG_IDX_MODE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic start;     // latch the incoming beat
        logic mod_step;  // one bit of node id reduction
        logic exec_wr;   // write one table entry
        logic clr_acc;   // clear match accumulators
        logic rd_en;     // issue one list entry
        logic rd_self;   // entry is the node itself (rank 0)
        logic rd_sel;    // 0: list of j, 1: list of i
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
        logic is_jacc;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### rtl/snnew_ctrl.sv
// snnew_ctrl: sequencing state machine for load and query beats.
// Depends on snnew_pkg (t_cmd, t_sts, ID_W, FRAC_W).
`default_nettype none

module snnew_ctrl #(
    parameter int NODES = snnew_pkg::NODES_DEF,
    parameter int KMAX  = snnew_pkg::KMAX_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  snnew_pkg::t_sts              i_sts,
    input  wire  [$clog2(KMAX+1)-1:0]          i_k,
    output snnew_pkg::t_cmd                    o_cmd,
    output logic [$clog2(KMAX+1)-1:0]          o_pos
);
    import snnew_pkg::*;

    localparam int  KW       = $clog2(KMAX + 1);
    localparam int  SW       = $clog2(KMAX + 2);
    localparam int  WW       = SW + FRAC_W;
    localparam bit  NEED_MOD = (NODES < (1 << ID_W));
    localparam int  CMAX1    = (KMAX + 1 > WW) ? KMAX + 1 : WW;
    localparam int  CMAX     = (CMAX1 > ID_W) ? CMAX1 : ID_W;
    localparam int  CW       = $clog2(CMAX + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_EXEC, S_FILL, S_SCAN, S_SETTLE, S_DINIT, S_DIV, S_DONE
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           cnt_at_k;

    assign cnt_at_k   = (r_cnt == CW'(i_k));
    assign o_in_ready = (r_state == S_IDLE);
    assign o_pos      = KW'(r_cnt);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = NEED_MOD ? S_MOD : S_EXEC;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(ID_W - 1)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_cnt = '0;
                if (i_sts.is_query) begin
                    o_cmd.clr_acc = 1'b1;
                    n_state       = S_FILL;
                end else begin
                    o_cmd.exec_wr = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_FILL, S_SCAN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = (r_state == S_SCAN);
                o_cmd.rd_self = (r_cnt == '0);
                if (cnt_at_k) begin
                    n_cnt   = '0;
                    n_state = (r_state == S_SCAN) ? S_SETTLE : S_SCAN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SETTLE: begin
                n_cnt   = '0;
                n_state = i_sts.is_jacc ? S_DINIT : S_DONE;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(WW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

### rtl/snnew_dp.sv
// snnew_dp: config registers, neighbor table memory, list buffer, match
// accumulators, Jaccard divider and output register. Depends on snnew_pkg.
`default_nettype none

module snnew_dp #(
    parameter int NODES = snnew_pkg::NODES_DEF,
    parameter int KMAX  = snnew_pkg::KMAX_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // config
    input  wire                                     i_cfg_we,
    input  wire                                     i_cfg_index,
    input  wire  [snnew_pkg::CFGK_W-1:0]            i_cfg_data,
    // request fields
    input  wire                                     i_req_type,
    input  wire  [snnew_pkg::ID_W-1:0]              i_node,
    input  wire  [snnew_pkg::SLOT_W-1:0]            i_slot,
    input  wire  [snnew_pkg::ID_W-1:0]              i_neighbor,
    input  wire  [snnew_pkg::ID_W-1:0]              i_other_node,
    // control
    input  wire  snnew_pkg::t_cmd                   i_cmd,
    input  wire  [$clog2(KMAX+1)-1:0]               i_pos,
    output snnew_pkg::t_sts                         o_sts,
    output logic [$clog2(KMAX+1)-1:0]               o_k,
    // result
    input  wire                                     i_out_ready,
    output logic                                    o_out_valid,
    output logic                                    o_edge_valid,
    output logic [snnew_pkg::WEIGHT_W-1:0]          o_weight,
    output logic [snnew_pkg::SCNT_W-1:0]            o_shared_count,
    output logic [snnew_pkg::BRANK_W-1:0]           o_best_rank
);
    import snnew_pkg::*;

    localparam int KW    = $clog2(KMAX + 1);
    localparam int SW    = $clog2(KMAX + 2);
    localparam int BW    = $clog2(2 * KMAX + 1);
    localparam int WW    = SW + FRAC_W;
    localparam int DW    = $clog2(2 * KMAX + 3);
    localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int VW    = (NW > ID_W) ? NW : ID_W;
    localparam int DEPTH = NODES * KMAX;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit NEED_MOD = (NODES < (1 << ID_W));

    // config
    logic [CFGK_W-1:0] r_cfg_k;
    logic [MODE_W-1:0] r_cfg_mode;
    logic              mode_rank, mode_jacc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k    <= K_RESET;
            r_cfg_mode <= MODE_COUNT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_K) begin
                r_cfg_k <= i_cfg_data;
            end else begin
                r_cfg_mode <= i_cfg_data[MODE_W-1:0];
            end
        end
    end

    assign o_k       = (7'(r_cfg_k) > 7'(KMAX)) ? KW'(KMAX) : KW'(r_cfg_k);
    assign mode_rank = (r_cfg_mode == MODE_RANK);
    assign mode_jacc = (r_cfg_mode == MODE_JACC);

    // request capture and node id reduction (mod NODES, one bit a cycle)
    logic                r_req;
    logic [SLOT_W-1:0]   r_slot;
    logic [ID_W-1:0]     r_nbr;
    logic [ID_W-1:0]     r_xi, r_xj;
    logic [NW-1:0]       r_ri, r_rj;
    logic [NW:0]         ti, tj;
    logic [NW-1:0]       node_i, node_j;

    assign ti = {r_ri, r_xi[ID_W-1]};
    assign tj = {r_rj, r_xj[ID_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req  <= i_req_type;
            r_slot <= i_slot;
            r_nbr  <= i_neighbor;
            r_xi   <= i_node;
            r_xj   <= i_other_node;
            r_ri   <= '0;
            r_rj   <= '0;
        end else if (i_cmd.mod_step) begin
            r_xi <= r_xi << 1;
            r_xj <= r_xj << 1;
            r_ri <= (ti >= (NW+1)'(NODES)) ? NW'(ti - (NW+1)'(NODES)) : NW'(ti);
            r_rj <= (tj >= (NW+1)'(NODES)) ? NW'(tj - (NW+1)'(NODES)) : NW'(tj);
        end
    end

    assign node_i = NEED_MOD ? r_ri : NW'(r_xi);
    assign node_j = NEED_MOD ? r_rj : NW'(r_xj);

    // neighbor table
    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rd_data;
    logic            wr_en, rd_mem;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [NW-1:0]   rd_node;

    assign wr_en   = i_cmd.exec_wr && (7'(r_slot) < 7'(KMAX));
    assign wr_addr = AW'(node_i) * AW'(KMAX) + AW'(r_slot);
    assign rd_node = i_cmd.rd_sel ? node_i : node_j;
    assign rd_addr = AW'(rd_node) * AW'(KMAX) + AW'(KW'(i_pos - 1'b1));
    assign rd_mem  = i_cmd.rd_en && !i_cmd.rd_self;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_nbr;
        end
        if (rd_mem) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // entry stage: registered alongside the memory read, so it lines up with the read data
    logic          r_p_vld, r_p_sel, r_p_self;
    logic [KW-1:0] r_p_pos;
    logic [VW-1:0] p_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_p_sel  <= i_cmd.rd_sel;
            r_p_self <= i_cmd.rd_self;
            r_p_pos  <= i_pos;
        end
    end

    assign p_val = r_p_self ? (r_p_sel ? VW'(node_i) : VW'(node_j)) : VW'(r_rd_data);

    // closed list of j, one register per rank
    logic [VW-1:0] r_lb [KMAX+1];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b <= KMAX; b++) begin
            if (r_p_vld && !r_p_sel && (r_p_pos == KW'(b))) begin
                r_lb[b] <= p_val;
            end
        end
    end

    // compare one entry of i against all of j; lowest matching rank wins
    logic          m_hit;
    logic [KW-1:0] m_bmin;
    logic [BW-1:0] cand;

    always_comb begin
        m_hit  = 1'b0;
        m_bmin = '0;
        for (int b = KMAX; b >= 0; b--) begin
            if ((r_lb[b] == p_val) && (KW'(b) <= o_k)) begin
                m_hit  = 1'b1;
                m_bmin = KW'(b);
            end
        end
    end

    assign cand = BW'(r_p_pos) + BW'(m_bmin);

    logic [SW-1:0] r_s;
    logic [BW-1:0] r_best;
    logic          r_have;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_s    <= '0;
            r_best <= '0;
            r_have <= 1'b0;
        end else if (r_p_vld && r_p_sel && m_hit) begin
            r_s <= r_s + 1'b1;
            if (!r_have || (cand < r_best)) begin
                r_best <= cand;
                r_have <= 1'b1;
            end
        end
    end

    // restoring divider: (s << 16) / (2(k+1) - s)
    logic [DW-1:0] den;
    logic [DW-1:0] r_rem;
    logic [WW-1:0] r_q;
    logic [DW:0]   dt;

    assign den = DW'(2 * (DW'(o_k) + 1'b1)) - DW'(r_s);
    assign dt  = {r_rem, r_q[WW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_q   <= WW'(r_s) << FRAC_W;
        end else if (i_cmd.div_step) begin
            if (dt >= {1'b0, den}) begin
                r_rem <= DW'(dt - {1'b0, den});
                r_q   <= {r_q[WW-2:0], 1'b1};
            end else begin
                r_rem <= DW'(dt);
                r_q   <= {r_q[WW-2:0], 1'b0};
            end
        end
    end

    // weight select and floor
    logic [WW-1:0] full, half, w_raw, w_fin;
    logic          edge_ok;

    assign full = WW'(o_k) << FRAC_W;
    assign half = WW'(r_best) << (FRAC_W - 1);

    always_comb begin
        priority if (mode_rank) begin
            w_raw = (full > half) ? (full - half) : '0;
        end else if (mode_jacc) begin
            w_raw = r_q;
        end else begin
            w_raw = WW'(r_s) << FRAC_W;
        end
        if (r_s == '0) begin
            w_fin = '0;
        end else if (w_raw == '0) begin
            w_fin = WW'(1);
        end else begin
            w_fin = w_raw;
        end
    end

    assign edge_ok = (r_s != '0) && (mode_rank ? (node_j != node_i) : (node_j < node_i));

    // output register
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_edge_valid   <= edge_ok;
            o_weight       <= WEIGHT_W'(w_fin);
            o_shared_count <= SCNT_W'(r_s);
            o_best_rank    <= BRANK_W'(r_best);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_sts.is_query  = (r_req == REQ_QUERY);
    assign o_sts.is_jacc   = mode_jacc;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

endmodule

`default_nettype wire

### rtl/snn_edge_weight.sv
// snn_edge_weight: shared-nearest-neighbor edge weight engine (top level).
// A load beat writes one table entry and returns to ready; a query reads k table
// entries per list on the single memory read port (rank 0 is the node itself), plus
// in Jaccard mode a setup step and 22 steps of the bit-serial divider; NODES below
// 1024 adds node id reduction, one bit per step. One beat in flight. Reset (sync, active
// low) clears control and config (k=10, shared count mode); the table is not cleared.
`default_nettype none

module snn_edge_weight #(
    parameter int NODES = snnew_pkg::NODES_DEF,  // table lists
    parameter int KMAX  = snnew_pkg::KMAX_DEF    // slots per list
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // config write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire                                 i_cfg_index,  // 0 neighbors_k, 1 weight_mode
    input  wire  [snnew_pkg::CFGK_W-1:0]        i_cfg_data,
    // request stream
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [9:0] node, [14:10] slot, [24:15] neighbor, [34:25] other_node, [39:35] zero
    input  wire  [snnew_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  wire  [0:0]                          i_s_axis_tuser,  // [0] req_type
    // result stream
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // [21:0] weight, [27:22] shared_count, [34:28] best_rank, [39:35] zero
    output logic [snnew_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic [0:0]                          o_m_axis_tuser   // [0] edge_valid
);
    import snnew_pkg::*;

    localparam int KW = $clog2(KMAX + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [KW-1:0] pos, k_eff;

    logic                 edge_valid;
    logic [WEIGHT_W-1:0]  weight;
    logic [SCNT_W-1:0]    shared_count;
    logic [BRANK_W-1:0]   best_rank;

    // config is always taken; software must only write while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    snnew_ctrl #(
        .NODES (NODES),
        .KMAX  (KMAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .i_k        (k_eff),
        .o_cmd      (cmd),
        .o_pos      (pos)
    );

    // unpack request beat straight into the datapath capture registers
    snnew_dp #(
        .NODES (NODES),
        .KMAX  (KMAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_s_axis_tuser[0]),
        .i_node         (i_s_axis_tdata[9:0]),
        .i_slot         (i_s_axis_tdata[14:10]),
        .i_neighbor     (i_s_axis_tdata[24:15]),
        .i_other_node   (i_s_axis_tdata[34:25]),
        .i_cmd          (cmd),
        .i_pos          (pos),
        .o_sts          (sts),
        .o_k            (k_eff),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_edge_valid   (edge_valid),
        .o_weight       (weight),
        .o_shared_count (shared_count),
        .o_best_rank    (best_rank)
    );

    // pack result beat, fields from bit 0 up
    assign o_m_axis_tdata = {5'b0, best_rank, shared_count, weight};
    assign o_m_axis_tuser = edge_valid;

`ifndef SYNTH
    // an accepted beat always takes the block out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready held after accept");

    // a result never overwrites one still waiting downstream
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over pending beat");

    // a table write finishes the load beat
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec_wr |=> o_s_axis_tready)
        else $error("load did not return to idle");

    // a valid edge needs two distinct nodes, so a summed rank of zero is impossible
    a_edge_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0] && (KMAX < 64))
            |-> (o_m_axis_tdata[34:28] != 7'd0))
        else $error("edge valid with self match only");
`endif

endmodule

`default_nettype wire

### test/snn_edge_weight_checker.sv
`timescale 1ns / 1ps
// snn_edge_weight_checker: watches the config, request and result channels of
// snn_edge_weight, predicts each query's edge result and compares it. Uses snnew_pkg.
module snn_edge_weight_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire                               i_cfg_index,
    input  wire [snnew_pkg::CFGK_W-1:0]       i_cfg_data,
    input  wire                               i_req_valid,
    input  wire                               i_req_ready,
    input  wire [snnew_pkg::IN_TDATA_W-1:0]   i_req_data,
    input  wire [0:0]                         i_req_user,
    input  wire                               i_res_valid,
    input  wire                               i_res_ready,
    input  wire [snnew_pkg::OUT_TDATA_W-1:0]  i_res_data,
    input  wire [0:0]                         i_res_user,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked
);
    import snnew_pkg::*;

    typedef struct packed {
        logic                edge_valid;
        logic [WEIGHT_W-1:0] weight;
        logic [SCNT_W-1:0]   shared_count;
        logic [BRANK_W-1:0]  best_rank;
    } t_edge_result;

    t_edge_result      edge_q[$];
    logic [ID_W-1:0]   nbr_mem [0:NODES_DEF-1][0:KMAX_DEF-1];
    logic [CFGK_W-1:0] k_reg = K_RESET;
    t_mode             mode_reg = MODE_COUNT;

    // closed lists: node itself at rank 0, slot n-1 at rank n
    function automatic t_edge_result predict_edge(input logic [ID_W-1:0] ni,
                                                  input logic [ID_W-1:0] nj);
        logic [ID_W-1:0]   list_i [0:KMAX_DEF];
        logic [ID_W-1:0]   list_j [0:KMAX_DEF];
        int                kk;
        int                s;
        int                best;
        bit                have;
        bit                hit;
        logic [63:0]       w;
        logic [63:0]       full;
        logic [63:0]       half;
        t_edge_result      r;
        kk = (k_reg > KMAX_DEF) ? KMAX_DEF : int'(k_reg);
        list_i[0] = ni;
        list_j[0] = nj;
        for (int n = 1; n <= kk; n++) begin
            list_i[n] = nbr_mem[ni][n-1];
            list_j[n] = nbr_mem[nj][n-1];
        end
        s    = 0;
        best = 0;
        have = 0;
        for (int a = 0; a <= kk; a++) begin
            hit = 0;
            for (int b = 0; b <= kk; b++) begin
                if (list_i[a] == list_j[b]) begin
                    hit = 1;
                    if (!have || a + b < best) begin
                        best = a + b;
                        have = 1;
                    end
                end
            end
            if (hit)
                s++;
        end
        w = 0;
        r.edge_valid = 1'b0;
        if (s > 0) begin
            case (mode_reg)
                MODE_RANK: begin
                    full = 64'(kk) << 16;
                    half = 64'(best) << 15;
                    w    = (full > half) ? full - half : 64'd0;
                end
                MODE_JACC: w = (64'(s) << 16) / 64'(2 * (kk + 1) - s);
                default:   w = 64'(s) << 16;
            endcase
            if (w == 0)
                w = 1;  // floor at one LSB
            r.edge_valid = (mode_reg == MODE_RANK) ? (nj != ni) : (nj < ni);
        end
        r.weight       = w[WEIGHT_W-1:0];
        r.shared_count = s[SCNT_W-1:0];
        r.best_rank    = best[BRANK_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_edge_result got;
        t_edge_result want;
        if (!i_rst_n) begin
            k_reg    = K_RESET;
            mode_reg = MODE_COUNT;
            edge_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_K)
                    k_reg = i_cfg_data;
                else
                    mode_reg = t_mode'(i_cfg_data[MODE_W-1:0]);
            end
            // pop before push: a result never belongs to the query accepted on its edge
            if (i_res_valid && i_res_ready) begin
                got.edge_valid   = i_res_user[0];
                got.weight       = i_res_data[WEIGHT_W-1:0];
                got.shared_count = i_res_data[WEIGHT_W +: SCNT_W];
                got.best_rank    = i_res_data[WEIGHT_W+SCNT_W +: BRANK_W];
                if (edge_q.size() == 0) begin
                    $error("result beat with no query outstanding (weight %0d)", got.weight);
                    o_errors++;
                end else begin
                    want = edge_q.pop_front();
                    o_checked++;
                    if (got.edge_valid !== want.edge_valid) begin
                        $error("edge_valid: expected %0d, got %0d",
                               want.edge_valid, got.edge_valid);
                        o_errors++;
                    end
                    if (got.weight !== want.weight) begin
                        $error("weight: expected %0d, got %0d", want.weight, got.weight);
                        o_errors++;
                    end
                    if (got.shared_count !== want.shared_count) begin
                        $error("shared_count: expected %0d, got %0d",
                               want.shared_count, got.shared_count);
                        o_errors++;
                    end
                    if (got.best_rank !== want.best_rank) begin
                        $error("best_rank: expected %0d, got %0d",
                               want.best_rank, got.best_rank);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_user[0] == REQ_LOAD)
                    nbr_mem[i_req_data[ID_W-1:0]][i_req_data[ID_W +: SLOT_W]] =
                        i_req_data[ID_W+SLOT_W +: ID_W];
                else
                    edge_q.push_back(predict_edge(i_req_data[ID_W-1:0],
                                                  i_req_data[2*ID_W+SLOT_W +: ID_W]));
            end
        end
        o_pending = edge_q.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench: stimulus and verdict for snn_edge_weight. Depends on snnew_pkg,
// the RTL and snn_edge_weight_checker, which predicts and compares results.
module testbench;
    import snnew_pkg::*;

    localparam int ITEMS_PER_PHASE = 102;
    localparam int DRAIN           = 120;   // longer than a worst-case query
    localparam int IDLE_LIMIT      = 4000;  // cycles with no beat accepted anywhere
    localparam int NUM_PHASES      = 12;

    // random phases: k and mode, extremes included (k=0, saturating k, mode 3)
    localparam int    PH_K    [NUM_PHASES] = '{1, 32, 0, 63, 33, 10, 1, 5, 16, 32, 20, 2};
    localparam t_mode PH_MODE [NUM_PHASES] = '{MODE_RANK, MODE_COUNT, MODE_JACC, MODE_RANK,
                                               MODE_JACC, MODE_ALT, MODE_JACC, MODE_RANK,
                                               MODE_COUNT, MODE_JACC, MODE_RANK, MODE_ALT};

    // directed table with k=2: mutual neighbors 0/1023, node 5 with a duplicate
    // entry, 20/22 sharing only their last entry (rank weight floors to one LSB),
    // node 7 sharing nothing with node 0
    localparam logic [ID_W-1:0] DIR_NODE [12] = '{0, 0, 1023, 1023, 5, 5, 20, 20,
                                                 22, 22, 7, 7};
    localparam logic [ID_W-1:0] DIR_NBR  [12] = '{1023, 5, 0, 5, 0, 0, 21, 30,
                                                 23, 30, 8, 9};
    // pairs: j<i, j>i, duplicates, j==i, floor case, no shared entry
    localparam logic [ID_W-1:0] DQ_I [6] = '{1023, 0, 5, 5, 22, 7};
    localparam logic [ID_W-1:0] DQ_J [6] = '{0, 1023, 0, 5, 20, 0};

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_index = 1'b0;
    logic [CFGK_W-1:0]       cfg_data  = '0;
    logic                    s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]              s_tuser   = '0;
    logic                    m_tready  = 1'b0;
    wire                     cfg_ready;
    wire                     s_tready;
    wire                     m_tvalid;
    wire  [OUT_TDATA_W-1:0]  m_tdata;
    wire  [0:0]              m_tuser;

    int errors;
    int pending;
    int checked;

    // stimulus bookkeeping: which slots of each list hold a written entry
    logic [KMAX_DEF-1:0] slot_done [0:NODES_DEF-1];
    logic [ID_W-1:0]     pool [0:15];
    int                  k_now      = 10;
    bit                  steady     = 1'b0;  // no gaps on either side when set
    int                  stall_left = 0;
    int                  idle_cycles = 0;
    int                  n_beats    = 0;
    int                  n_queries  = 0;
    int                  n_settings = 0;

    always #4 i_clk = ~i_clk;

    snn_edge_weight uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    snn_edge_weight_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req_valid (s_tvalid),
        .i_req_ready (s_tready),
        .i_req_data  (s_tdata),
        .i_req_user  (s_tuser),
        .i_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .i_res_data  (m_tdata),
        .i_res_user  (m_tuser),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // gap length: mostly short, some medium, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady && $urandom_range(0, 99) < 15) begin
            m_tready   <= 1'b0;
            stall_left <= gap_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog: any accepted beat on any channel restarts the count
    always @(posedge i_clk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // list of n covers every slot that the current k reads
    function automatic bit list_ready(input logic [ID_W-1:0] n);
        logic [KMAX_DEF-1:0] mask;
        int                  kk;
        kk = (k_now > KMAX_DEF) ? KMAX_DEF : k_now;
        if (kk == 0)
            return 1'b1;
        mask = (kk == KMAX_DEF) ? '1 : KMAX_DEF'((64'd1 << kk) - 1);
        return (slot_done[n] & mask) == mask;
    endfunction

    function automatic int first_gap(input logic [ID_W-1:0] n);
        for (int s = 0; s < KMAX_DEF; s++)
            if (!slot_done[n][s])
                return s;
        return 0;
    endfunction

    // neighbors mostly from the pool so lists overlap
    function automatic logic [ID_W-1:0] pick_neighbor();
        if ($urandom_range(0, 9) < 7)
            return pool[$urandom_range(0, 15)];
        return ID_W'($urandom);
    endfunction

    // valid stays high across back-to-back beats; lowered only ahead of a gap
    task automatic send_beat(input logic user, input logic [IN_TDATA_W-1:0] data);
        int gap;
        gap = (!steady && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= user;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        n_beats++;
    endtask

    // unused fields carry random bits; top pad bits stay zero
    task automatic send_load(input logic [ID_W-1:0] n, input logic [SLOT_W-1:0] sl,
                             input logic [ID_W-1:0] nb);
        slot_done[n][sl] = 1'b1;
        send_beat(REQ_LOAD, {5'b0, ID_W'($urandom), nb, sl, n});
    endtask

    task automatic send_query(input logic [ID_W-1:0] ni, input logic [ID_W-1:0] nj);
        n_queries++;
        send_beat(REQ_QUERY, {5'b0, nj, ID_W'($urandom), SLOT_W'($urandom), ni});
    endtask

    // quiet point: nothing outstanding, then room for a trailing load to finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFGK_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // mode beat carries random upper data bits, which the block must drop
    task automatic set_config(input int k, input t_mode mode);
        wait_idle();
        cfg_write(CFG_IDX_K, CFGK_W'(k));
        cfg_write(CFG_IDX_MODE, {4'($urandom), mode});
        cfg_valid <= 1'b0;
        k_now = k;
        n_settings++;
    endtask

    // well-formed traffic: fill pool lists up to k, then query pool pairs;
    // a share of overwrites and stray loads to arbitrary nodes mixed in
    task automatic random_item();
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] q;
        int              r;
        r = $urandom_range(0, 99);
        p = pool[$urandom_range(0, 15)];
        if (r < 8) begin
            send_load(ID_W'($urandom), SLOT_W'($urandom), ID_W'($urandom));
        end else if (!list_ready(p)) begin
            send_load(p, SLOT_W'(first_gap(p)), pick_neighbor());
        end else if (r < 25) begin
            send_load(p, SLOT_W'($urandom), pick_neighbor());
        end else begin
            q = ($urandom_range(0, 9) == 0) ? p : pool[$urandom_range(0, 15)];
            if (!list_ready(q))
                send_load(q, SLOT_W'(first_gap(q)), pick_neighbor());
            else
                send_query(p, q);
        end
    endtask

    initial begin
        for (int n = 0; n < NODES_DEF; n++)
            slot_done[n] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: small table, each special pair in rank then jaccard mode
        set_config(2, MODE_RANK);
        for (int d = 0; d < 12; d++)
            send_load(DIR_NODE[d], SLOT_W'(d % 2), DIR_NBR[d]);
        for (int d = 0; d < 6; d++)
            send_query(DQ_I[d], DQ_J[d]);
        set_config(2, MODE_JACC);
        for (int d = 0; d < 6; d++)
            send_query(DQ_I[d], DQ_J[d]);

        // random part: extreme node ids always in the pool
        pool[0] = '0;
        pool[1] = '1;
        for (int p = 2; p < 16; p++)
            pool[p] = ID_W'($urandom);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            steady = (ph % 4 == 3);
            set_config(PH_K[ph], PH_MODE[ph]);
            repeat (ITEMS_PER_PHASE) random_item();
        end
        steady = 1'b0;
        wait_idle();

        $display("covered %0d request beats (%0d queries) over %0d k/mode settings",
                 n_beats, n_queries, n_settings);
        $display("%0d edge results compared field by field", checked);
        if (errors == 0 && pending == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/snnew_pkg.sv
rtl/snnew_ctrl.sv
rtl/snnew_dp.sv
rtl/snn_edge_weight.sv
test/snn_edge_weight_checker.sv
test/testbench.sv
